### src/dsqrt_pkg.sv
// Shared types and constants for the decimal square root block.
// No dependencies; used by dsqrt_engine and decimal_square_root.
package dsqrt_pkg;

  localparam int INT_W      = 16;  // root_integer width
  localparam int FRAC_W     = 20;  // root_fraction width
  localparam int DIGITS_W   = 3;   // fraction_digits register width
  localparam int OUT_DATA_W = 40;  // INT_W + FRAC_W rounded up to bytes
  localparam int OUT_PAD_W  = OUT_DATA_W - INT_W - FRAC_W;

  localparam logic [DIGITS_W-1:0] DIGITS_RESET = 3'd3;
  localparam logic [3:0]          DIGIT_MAX    = 4'd9;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_INT  = 5'b00010,
    ST_PREP = 5'b00100,
    ST_DIG  = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

  typedef struct packed {
    logic [INT_W-1:0]  root_integer;
    logic [FRAC_W-1:0] root_fraction;
    logic              negative_error;
  } result_t;

  typedef struct packed {
    logic idle;
    logic done;
  } eng_status_t;

  // Elaboration-time power of ten, used for width sizing only
  function automatic longint unsigned pow10(input int n);
    longint unsigned acc;
    acc = 1;
    for (int i = 0; i < n; i++) begin
      acc = acc * 10;
    end
    return acc;
  endfunction

endpackage

### src/dsqrt_engine.sv
// Digit-serial root engine: binary restoring root, then decimal digits.
// Depends on dsqrt_pkg.
module dsqrt_engine #(
  parameter int RADICAND_BITS       = 32,
  parameter int MAX_FRACTION_DIGITS = 6
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [RADICAND_BITS-1:0]         radicand_i,
  input  logic [dsqrt_pkg::DIGITS_W-1:0]   digits_i,
  input  logic                             ack_i,
  output dsqrt_pkg::eng_status_t           status_o,
  output dsqrt_pkg::result_t               result_o
);

  localparam int IB  = (RADICAND_BITS + 1) / 2;
  localparam int RW  = IB + $clog2(dsqrt_pkg::pow10(MAX_FRACTION_DIGITS));
  localparam int RMW = RW + 3;
  localparam int TW  = RW + 8;
  localparam int CW  = $clog2(IB + 1);
  localparam int DCW = $clog2(MAX_FRACTION_DIGITS + 2);

  dsqrt_pkg::state_e state_q, state_d;

  logic [2*IB-1:0]                 rad_q, rad_d;
  logic [RW-1:0]                   r_q, r_d;
  logic [RMW-1:0]                  rem_q, rem_d;
  logic [TW-1:0]                   target_q, target_d;
  logic [TW-1:0]                   odd_q, odd_d;
  logic [dsqrt_pkg::FRAC_W-1:0]    frac_q, frac_d;
  logic [IB-1:0]                   int_q, int_d;
  logic [3:0]                      t_q, t_d;
  logic [CW-1:0]                   cnt_q, cnt_d;
  logic [DCW-1:0]                  left_q, left_d;
  logic                            neg_q, neg_d;

  logic [RMW-1:0] rem_shift;
  logic [RMW-1:0] trial;
  logic [DCW-1:0] digits_eff;

  // Two radicand bits per step into the partial remainder
  assign rem_shift = (rem_q << 2) | RMW'(rad_q[2*IB-1 -: 2]);
  assign trial     = (RMW'(r_q) << 2) | RMW'(1);

  always_comb begin
    if (int'(digits_i) > MAX_FRACTION_DIGITS) begin
      digits_eff = DCW'(MAX_FRACTION_DIGITS);
    end else begin
      digits_eff = DCW'(digits_i);
    end
  end

  always_comb begin
    state_d  = state_q;
    rad_d    = rad_q;
    r_d      = r_q;
    rem_d    = rem_q;
    target_d = target_q;
    odd_d    = odd_q;
    frac_d   = frac_q;
    int_d    = int_q;
    t_d      = t_q;
    cnt_d    = cnt_q;
    left_d   = left_q;
    neg_d    = neg_q;
    case (state_q)
      dsqrt_pkg::ST_IDLE: begin
        if (start_i) begin
          neg_d  = radicand_i[RADICAND_BITS-1];
          rad_d  = (2*IB)'(radicand_i[RADICAND_BITS-2:0]);
          r_d    = '0;
          rem_d  = '0;
          frac_d = '0;
          int_d  = '0;
          cnt_d  = CW'(IB);
          left_d = digits_eff;
          if (radicand_i[RADICAND_BITS-1]) begin
            state_d = dsqrt_pkg::ST_DONE;
          end else begin
            state_d = dsqrt_pkg::ST_INT;
          end
        end
      end
      dsqrt_pkg::ST_INT: begin
        rad_d = rad_q << 2;
        cnt_d = cnt_q - CW'(1);
        if (rem_shift >= trial) begin
          rem_d = rem_shift - trial;
          r_d   = (r_q << 1) | RW'(1);
        end else begin
          rem_d = rem_shift;
          r_d   = r_q << 1;
        end
        if (cnt_q == CW'(1)) begin
          int_d = r_d[IB-1:0];
          if (left_q == '0) begin
            state_d = dsqrt_pkg::ST_DONE;
          end else begin
            state_d = dsqrt_pkg::ST_PREP;
          end
        end
      end
      dsqrt_pkg::ST_PREP: begin
        // target = rem * 100, odd = 20 * r + 1
        target_d = (TW'(rem_q) << 6) + (TW'(rem_q) << 5) + (TW'(rem_q) << 2);
        odd_d    = (TW'(r_q) << 4) + (TW'(r_q) << 2) + TW'(1);
        t_d      = '0;
        state_d  = dsqrt_pkg::ST_DIG;
      end
      dsqrt_pkg::ST_DIG: begin
        // cost(t) - cost(t-1) = 20r + 2t - 1: peel off odd terms
        if (target_q >= odd_q && t_q != dsqrt_pkg::DIGIT_MAX) begin
          target_d = target_q - odd_q;
          odd_d    = odd_q + TW'(2);
          t_d      = t_q + 4'd1;
        end else begin
          rem_d  = RMW'(target_q);
          r_d    = (r_q << 3) + (r_q << 1) + RW'(t_q);
          frac_d = (frac_q << 3) + (frac_q << 1) + dsqrt_pkg::FRAC_W'(t_q);
          left_d = left_q - DCW'(1);
          if (left_q == DCW'(1)) begin
            state_d = dsqrt_pkg::ST_DONE;
          end else begin
            state_d = dsqrt_pkg::ST_PREP;
          end
        end
      end
      dsqrt_pkg::ST_DONE: begin
        if (ack_i) begin
          state_d = dsqrt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dsqrt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dsqrt_pkg::ST_IDLE;
      cnt_q   <= '0;
      left_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      left_q  <= left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q    <= rad_d;
    r_q      <= r_d;
    rem_q    <= rem_d;
    target_q <= target_d;
    odd_q    <= odd_d;
    frac_q   <= frac_d;
    int_q    <= int_d;
    t_q      <= t_d;
    neg_q    <= neg_d;
  end

  assign status_o.idle = (state_q == dsqrt_pkg::ST_IDLE);
  assign status_o.done = (state_q == dsqrt_pkg::ST_DONE);

  assign result_o.root_integer   = dsqrt_pkg::INT_W'(int_q);
  assign result_o.root_fraction  = frac_q;
  assign result_o.negative_error = neg_q;

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dsqrt_pkg::ST_DIG) |-> (t_q <= dsqrt_pkg::DIGIT_MAX))
    else $error("decimal digit out of range");

  a_neg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dsqrt_pkg::ST_DONE && neg_q) |-> (int_q == '0 && frac_q == '0))
    else $error("negative radicand with non-zero root");

  a_start_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && state_q == dsqrt_pkg::ST_IDLE) |=> (state_q != dsqrt_pkg::ST_IDLE))
    else $error("engine stayed idle after start");

  a_ack_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ack_i && state_q == dsqrt_pkg::ST_DONE) |=> (state_q == dsqrt_pkg::ST_IDLE))
    else $error("engine not released after result taken");

endmodule

### src/decimal_square_root.sv
// Decimal square root: floor(sqrt(radicand) * 10^digits), split into parts.
// The engine forms ceil(RADICAND_BITS/2) integer root bits (16 at defaults), then up to
//   MAX_FRACTION_DIGITS (6) decimal digits; a negative radicand skips both.
// One item in the engine at a time; s_axis_tready returns once the result moves to the
//   output register, so a new item can be taken while that result waits there.
// The root loop takes 2 bits/cycle; each digit unit costs one subtract. Async active-low reset.
module decimal_square_root #(
  parameter int RADICAND_BITS       = 32,
  parameter int MAX_FRACTION_DIGITS = 6
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration: fraction_digits
  input  logic                                cfg_wr_en_i,
  input  logic [dsqrt_pkg::DIGITS_W-1:0]      cfg_wr_data_i,
  // input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: radicand (RADICAND_BITS, signed), zero padding to whole bytes
  input  logic [((RADICAND_BITS+7)/8)*8-1:0]  s_axis_tdata,
  // output stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata: root_integer [15:0], root_fraction [35:16], zero padding [39:36]
  output logic [dsqrt_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // tuser: negative_error
  output logic                                m_axis_tuser
);

  logic [dsqrt_pkg::DIGITS_W-1:0] digits_q;

  dsqrt_pkg::eng_status_t eng_status;
  dsqrt_pkg::result_t     eng_result;
  dsqrt_pkg::result_t     out_q;
  logic                   out_valid_q;
  logic                   start;
  logic                   load_out;

  // fraction_digits register; the user writes it only between items, not enforced here
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digits_q <= dsqrt_pkg::DIGITS_RESET;
    end else if (cfg_wr_en_i) begin
      digits_q <= cfg_wr_data_i;
    end
  end

  // A transfer is taken whenever the engine is free, even with a result parked
  assign s_axis_tready = eng_status.idle;
  assign start         = s_axis_tvalid && eng_status.idle;

  // Result moves to the output register when it is empty or being drained
  assign load_out = eng_status.done && (!out_valid_q || m_axis_tready);

  dsqrt_engine #(
    .RADICAND_BITS       (RADICAND_BITS),
    .MAX_FRACTION_DIGITS (MAX_FRACTION_DIGITS)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .radicand_i (s_axis_tdata[RADICAND_BITS-1:0]),
    .digits_i   (digits_q),
    .ack_i      (load_out),
    .status_o   (eng_status),
    .result_o   (eng_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= eng_result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{dsqrt_pkg::OUT_PAD_W{1'b0}}, out_q.root_fraction,
                          out_q.root_integer};
  assign m_axis_tuser  = out_q.negative_error;

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second transfer taken while engine busy");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |-> !load_out)
    else $error("pending result overwritten");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> m_axis_tvalid)
    else $error("loaded result not presented");

endmodule

### tb/tb_decimal_square_root.sv
// Self-checking testbench for decimal_square_root: random and directed radicands.
// Needs dsqrt_pkg and decimal_square_root; the expected roots come from an exact wide isqrt.
module tb_decimal_square_root;

  localparam int RADICAND_W  = 32;
  localparam int DIGITS_CAP  = 6;
  localparam int HALF_PERIOD = 6;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 60;

  logic                                 clk_i = 1'b0;
  logic                                 rst_ni;
  logic                                 cfg_wr_en_i;
  logic [dsqrt_pkg::DIGITS_W-1:0]       cfg_wr_data_i;
  logic                                 s_axis_tvalid;
  logic                                 s_axis_tready;
  logic [RADICAND_W-1:0]                s_axis_tdata;   // radicand [31:0]
  logic                                 m_axis_tvalid;
  logic                                 m_axis_tready;
  logic [dsqrt_pkg::OUT_DATA_W-1:0]     m_axis_tdata;   // root_integer, root_fraction, padding
  logic                                 m_axis_tuser;   // negative_error

  // Gap limits, redrawn per phase so some phases run back to back
  int unsigned gap_max   = 14;
  int unsigned stall_max = 14;

  // Digit counts for the random phases; 7 checks saturation to six
  logic [dsqrt_pkg::DIGITS_W-1:0] phase_digits [PHASES] = '{6, 0, 7, 1, 2, 4, 5, 3};

  // Holds the digit setting and the roots still owed by the block
  class root_scoreboard;
    logic [dsqrt_pkg::DIGITS_W-1:0] fraction_digits;
    dsqrt_pkg::result_t             expected_roots[$];
    int unsigned                    mismatch_count;

    function new();
      fraction_digits = dsqrt_pkg::DIGITS_RESET;
      mismatch_count  = 0;
    endfunction

    // floor(sqrt(radicand) * 10^d) == isqrt(radicand * 100^d), split by 10^d
    function dsqrt_pkg::result_t predict_root(logic [RADICAND_W-1:0] radicand);
      dsqrt_pkg::result_t res;
      logic [79:0]        scale;
      logic [79:0]        scaled;
      logic [79:0]        trial;
      logic [79:0]        acc;
      int unsigned        used_digits;
      int                 bit_idx;
      res = '0;
      if (radicand[RADICAND_W-1]) begin
        res.negative_error = 1'b1;
        return res;
      end
      used_digits = (fraction_digits > DIGITS_CAP) ? DIGITS_CAP : fraction_digits;
      scale = 80'd1;
      repeat (used_digits) scale = scale * 80'd10;
      scaled = {48'b0, radicand} * scale * scale;
      acc = '0;
      for (bit_idx = 39; bit_idx >= 0; bit_idx--) begin
        trial = acc | (80'd1 << bit_idx);
        if (trial * trial <= scaled) begin
          acc = trial;
        end
      end
      res.root_integer  = dsqrt_pkg::INT_W'(acc / scale);
      res.root_fraction = dsqrt_pkg::FRAC_W'(acc % scale);
      return res;
    endfunction

    function void note_radicand(logic [RADICAND_W-1:0] radicand);
      expected_roots.push_back(predict_root(radicand));
    endfunction

    task report_mismatch(string what, longint unsigned want, longint unsigned got);
      mismatch_count++;
      $display("MISMATCH %s: expected %0d, got %0d", what, want, got);
    endtask

    task check_root(dsqrt_pkg::result_t got);
      dsqrt_pkg::result_t want;
      if (expected_roots.size() == 0) begin
        report_mismatch("unexpected result transfer, queued", 0, 1);
        return;
      end
      want = expected_roots.pop_front();
      if (got.root_integer != want.root_integer)
        report_mismatch("root_integer", want.root_integer, got.root_integer);
      if (got.root_fraction != want.root_fraction)
        report_mismatch("root_fraction", want.root_fraction, got.root_fraction);
      if (got.negative_error != want.negative_error)
        report_mismatch("negative_error", want.negative_error, got.negative_error);
    endtask
  endclass

  root_scoreboard sb;

  decimal_square_root #(
    .RADICAND_BITS      (RADICAND_W),
    .MAX_FRACTION_DIGITS(DIGITS_CAP)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // Both transfers observed at the rising edge, before the block's own updates land
  always @(posedge clk_i) begin
    dsqrt_pkg::result_t got;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_radicand(s_axis_tdata);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.root_integer   = m_axis_tdata[dsqrt_pkg::INT_W-1:0];
        got.root_fraction  = m_axis_tdata[dsqrt_pkg::INT_W+dsqrt_pkg::FRAC_W-1:dsqrt_pkg::INT_W];
        got.negative_error = m_axis_tuser;
        sb.check_root(got);
      end
    end
  end

  // Radicand mix: negatives, small values, near-squares, full 31-bit range
  function automatic logic [RADICAND_W-1:0] random_radicand();
    int unsigned pick;
    int unsigned base;
    logic [RADICAND_W-1:0] sq;
    pick = $urandom_range(0, 9);
    case (pick)
      0: begin
        return {1'b1, 31'($urandom)};
      end
      1, 2: begin
        return RADICAND_W'($urandom_range(0, 255));
      end
      3, 4: begin
        base = $urandom_range(1, 46340);
        sq   = base * base;
        return sq + RADICAND_W'($urandom_range(0, 2)) - 1;
      end
      default: begin
        return {1'b0, 31'($urandom)};
      end
    endcase
  endfunction

  // One input transfer; returns at the edge where it is taken
  task automatic drive_radicand(input logic [RADICAND_W-1:0] value);
    int unsigned gap;
    gap = $urandom_range(0, gap_max);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Sender holds off until every owed root has come back
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.expected_roots.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_digits(input logic [dsqrt_pkg::DIGITS_W-1:0] value);
    @(negedge clk_i);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= value;
    @(negedge clk_i);
    cfg_wr_en_i <= 1'b0;
    sb.fraction_digits = value;
  endtask

  // Result sink: random stall before each transfer
  initial begin
    int unsigned stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = $urandom_range(0, stall_max);
      @(negedge clk_i);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  initial begin
    int phase;
    sb            = new();
    rst_ni        = 1'b0;
    cfg_wr_en_i   = 1'b0;
    cfg_wr_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset setting of three digits: zero, tiny values, perfect squares, both extremes
    drive_radicand(32'd0);
    drive_radicand(32'd1);
    drive_radicand(32'd2);
    drive_radicand(32'd3);
    drive_radicand(32'd4);
    drive_radicand(32'd99);
    drive_radicand(32'd100);
    drive_radicand(32'd2147395600);   // 46340 squared
    drive_radicand(32'd2147395599);
    drive_radicand(32'h7FFF_FFFF);
    drive_radicand(32'h8000_0000);
    drive_radicand(32'hFFFF_FFFF);

    // Widest fraction, then the out-of-range count that must saturate, then none
    wait_drained();
    write_digits(dsqrt_pkg::DIGITS_W'(6));
    drive_radicand(32'h7FFF_FFFF);
    drive_radicand(32'd2);
    drive_radicand(32'd0);
    wait_drained();
    write_digits(dsqrt_pkg::DIGITS_W'(7));
    drive_radicand(32'h7FFF_FFFF);
    drive_radicand(32'd2);
    drive_radicand(32'h8000_0001);
    wait_drained();
    write_digits(dsqrt_pkg::DIGITS_W'(0));
    drive_radicand(32'h7FFF_FFFF);
    drive_radicand(32'd2);
    drive_radicand(32'd0);

    for (phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      write_digits(phase_digits[phase]);
      gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 14;
      stall_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
      repeat (PHASE_ITEMS) drive_radicand(random_radicand());
    end

    wait_drained();
    repeat (100) @(negedge clk_i);
    if (sb.mismatch_count == 0 && sb.expected_roots.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #(2 * HALF_PERIOD * 600000);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
